### design/rrs_pkg.sv
`timescale 1ns / 1ps

package rrs_pkg;

    // Field and register widths.
    localparam int DIM_W     = 13;
    localparam int ROW_W     = 12;
    localparam int RAD_W     = 12;
    localparam int PQ_W      = 14;
    localparam int N_W       = 26;
    localparam int ROOT_W    = 13;
    localparam int REM_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int QUEUE_DEPTH     = 4;
    localparam int DEFAULT_MAX_DIM = 4096;

    localparam logic [DIM_W-1:0] RADIUS_RESET = 13'd18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_CORNER_RADIUS = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] radius;
    } t_cfg;

    // One classified row on its way to the square root pipeline.
    typedef struct packed {
        logic             below;
        logic             corner;
        logic [RAD_W-1:0] radius;
        logic [DIM_W-1:0] width;
        logic [N_W-1:0]   n;
    } t_job;

endpackage

### design/rrs_front.sv
`timescale 1ns / 1ps

module rrs_front import rrs_pkg::*; #(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_row_valid,
    output logic             o_row_ready,
    input  logic [ROW_W-1:0] i_row_index,
    input  logic             i_queue_full,
    output logic             o_push,
    output t_job             o_push_job
);

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic [DIM_W-1:0] w_w, w_h, w_r0, w_min, w_y, w_hr, w_diff;
    logic [DIM_W-1:0] w_d_top, w_d_bot;
    logic [RAD_W-1:0] w_half, w_r;
    logic             w_below, w_top, w_bottom;
    logic             w_front_en;

    always_comb begin
        w_w     = sat_dim(i_cfg.width);
        w_h     = sat_dim(i_cfg.height);
        w_r0    = sat_dim(i_cfg.radius);
        w_min   = (w_w < w_h) ? w_w : w_h;
        w_half  = w_min[DIM_W-1:1];
        w_r     = (w_r0 > {1'b0, w_half}) ? w_half : w_r0[RAD_W-1:0];
        w_y     = {1'b0, i_row_index};
        w_below = (w_y >= w_h);
        w_top   = (w_r != '0) && (w_y < {1'b0, w_r});
        w_hr    = w_h - {1'b0, w_r};
        w_bottom = (w_r != '0) && !w_top && (w_y >= w_hr);
        // Twice the vertical distance from the pixel centre to the corner centre, always odd.
        w_d_top = {w_r, 1'b0} - {i_row_index, 1'b0} - DIM_W'(1);
        w_diff  = w_y - w_hr;
        w_d_bot = {w_diff[RAD_W-1:0], 1'b0} + DIM_W'(1);
    end

    logic             r_f1_valid, r_f1_below, r_f1_corner;
    logic [RAD_W-1:0] r_f1_radius;
    logic [DIM_W-1:0] r_f1_width, r_f1_d;

    logic             r_f2_valid, r_f2_below, r_f2_corner;
    logic [RAD_W-1:0] r_f2_radius;
    logic [DIM_W-1:0] r_f2_width;
    logic [PQ_W-1:0]  r_f2_p, r_f2_q;

    logic             r_f3_valid;
    t_job             r_f3_job;

    assign w_front_en  = !r_f3_valid || !i_queue_full;
    assign o_row_ready = w_front_en;
    assign o_push      = r_f3_valid && !i_queue_full;
    assign o_push_job  = r_f3_job;

    logic [PQ_W-1:0]   w_two_r;
    logic [2*PQ_W-1:0] w_prod;

    // 4r^2 - d^2 is formed as (2r - d)(2r + d), so one multiplier suffices.
    assign w_two_r = {1'b0, r_f1_radius, 1'b0};
    assign w_prod  = r_f2_p * r_f2_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (w_front_en) begin
            r_f1_valid <= i_row_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_front_en) begin
            r_f1_below  <= w_below;
            r_f1_corner <= (w_top || w_bottom) && !w_below;
            r_f1_radius <= w_r;
            r_f1_width  <= w_w;
            r_f1_d      <= w_top ? w_d_top : w_d_bot;

            r_f2_below  <= r_f1_below;
            r_f2_corner <= r_f1_corner;
            r_f2_radius <= r_f1_radius;
            r_f2_width  <= r_f1_width;
            r_f2_p      <= r_f1_corner ? (w_two_r - {1'b0, r_f1_d}) : '0;
            r_f2_q      <= r_f1_corner ? (w_two_r + {1'b0, r_f1_d}) : '0;

            r_f3_job.below  <= r_f2_below;
            r_f3_job.corner <= r_f2_corner;
            r_f3_job.radius <= r_f2_radius;
            r_f3_job.width  <= r_f2_width;
            r_f3_job.n      <= w_prod[N_W-1:0];
        end
    end

endmodule

### design/rrs_queue.sv
`timescale 1ns / 1ps

module rrs_queue import rrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_pop_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_pop_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue occupancy did not follow a lone push");
`endif

endmodule

### design/rrs_back.sv
`timescale 1ns / 1ps

module rrs_back import rrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_queue_valid,
    input  t_job             i_queue_job,
    output logic             o_pop,
    output logic             o_span_valid,
    input  logic             i_span_ready,
    output logic [RAD_W-1:0] o_span_start,
    output logic [DIM_W-1:0] o_span_length,
    output logic             o_span_present
);

    logic             r_out_valid;
    logic             r_out_present;
    logic [RAD_W-1:0] r_out_start;
    logic [DIM_W-1:0] r_out_length;

    logic w_back_en;

    assign w_back_en = !r_out_valid || i_span_ready;
    assign o_pop     = w_back_en && i_queue_valid;

    // Stage inputs; index s feeds square root stage s.
    logic              s_vld  [0:ROOT_W-1];
    t_job              s_job  [0:ROOT_W-1];
    logic [ROOT_W-1:0] s_root [0:ROOT_W-1];
    logic [REM_W-1:0]  s_rem  [0:ROOT_W-1];

    // Stage outputs; index s is written by stage s-1.
    logic              r_vld  [1:ROOT_W];
    t_job              r_job  [1:ROOT_W];
    logic [ROOT_W-1:0] r_root [1:ROOT_W];
    logic [REM_W-1:0]  r_rem  [1:ROOT_W-1];

    // One root bit per stage, most significant first.
    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int PAIR = ROOT_W - 1 - s;

        logic [REM_W-1:0]  w_rem_sh, w_trial;
        logic [ROOT_W-1:0] w_root_nx;
        logic              w_take;

        if (s == 0) begin : g_first
            assign s_vld[s]  = i_queue_valid;
            assign s_job[s]  = i_queue_job;
            assign s_root[s] = '0;
            assign s_rem[s]  = '0;
        end else begin : g_next
            assign s_vld[s]  = r_vld[s];
            assign s_job[s]  = r_job[s];
            assign s_root[s] = r_root[s];
            assign s_rem[s]  = r_rem[s];
        end

        assign w_rem_sh  = {s_rem[s][REM_W-3:0], s_job[s].n[2*PAIR+1:2*PAIR]};
        assign w_trial   = {1'b0, s_root[s], 2'b01};
        assign w_take    = (w_rem_sh >= w_trial);
        assign w_root_nx = {s_root[s][ROOT_W-2:0], w_take};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (w_back_en) begin
                r_vld[s+1] <= s_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_back_en) begin
                r_job[s+1]  <= s_job[s];
                r_root[s+1] <= w_root_nx;
            end
        end

        if (s < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_back_en) begin
                    r_rem[s+1] <= w_take ? (w_rem_sh - w_trial) : w_rem_sh;
                end
            end
        end
    end

    t_job              w_last;
    logic [ROOT_W-1:0] w_root;
    logic [RAD_W-1:0]  w_inset;
    logic [DIM_W-1:0]  w_two_inset;
    logic              w_present;

    assign w_last      = r_job[ROOT_W];
    assign w_root      = r_root[ROOT_W];
    assign w_inset     = w_last.corner ? (w_last.radius - w_root[ROOT_W-1:1]) : '0;
    assign w_two_inset = {w_inset, 1'b0};
    assign w_present   = !w_last.below && (w_last.width > w_two_inset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_back_en) begin
            r_out_valid <= r_vld[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_back_en) begin
            r_out_present <= w_present;
            r_out_start   <= w_present ? w_inset : '0;
            r_out_length  <= w_present ? (w_last.width - w_two_inset) : '0;
        end
    end

    assign o_span_valid   = r_out_valid;
    assign o_span_present = r_out_present;
    assign o_span_start   = r_out_start;
    assign o_span_length  = r_out_length;

`ifndef NO_ASSERTIONS
    a_empty_span_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_present) |-> (r_out_start == '0 && r_out_length == '0))
        else $error("a row without a span carries a nonzero start or length");

    a_span_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_present) |-> (r_out_length != '0))
        else $error("a row marked as holding a span has zero length");
`endif

endmodule

### design/rounded_rect_row_span_top.sv
// Rounded-rectangle row span: one row request in, one span result out.
// Throughput: one row per cycle, sustained while the output side keeps taking results.
// Path from request to result: three front stages,
// one queue slot, a 13-stage bit-per-stage square root and the output register.
// Reset is synchronous and active low; it empties the pipelines and queue and
// returns the registers to width 0, height 0 and radius 18.
`timescale 1ns / 1ps

module rounded_rect_row_span_top import rrs_pkg::*; #(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_row_valid,
    output logic                 o_row_ready,
    input  logic [ROW_W-1:0]     i_row_index,
    output logic                 o_span_valid,
    input  logic                 i_span_ready,
    output logic [RAD_W-1:0]     o_span_start,
    output logic [DIM_W-1:0]     o_span_length,
    output logic                 o_span_present
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    // A write to an index beyond the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= '0;
            r_cfg.height <= '0;
            r_cfg.radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FRAME_WIDTH:   r_cfg.width  <= i_cfg_data;
                REG_FRAME_HEIGHT:  r_cfg.height <= i_cfg_data;
                REG_CORNER_RADIUS: r_cfg.radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_push, w_full, w_pop, w_queue_valid;
    t_job w_push_job, w_pop_job;

    rrs_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_row_valid  (i_row_valid),
        .o_row_ready  (o_row_ready),
        .i_row_index  (i_row_index),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_push_job   (w_push_job)
    );

    rrs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_valid    (w_queue_valid),
        .o_pop_job  (w_pop_job)
    );

    rrs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_valid  (w_queue_valid),
        .i_queue_job    (w_pop_job),
        .o_pop          (w_pop),
        .o_span_valid   (o_span_valid),
        .i_span_ready   (i_span_ready),
        .o_span_start   (o_span_start),
        .o_span_length  (o_span_length),
        .o_span_present (o_span_present)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rrs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 40;
    // Index 3 is not decoded by the block; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [RAD_W-1:0] start;
        logic [DIM_W-1:0] length;
        logic             present;
    } span_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 i_row_valid = 1'b0;
    logic                 o_row_ready;
    logic [ROW_W-1:0]     i_row_index = '0;
    logic                 o_span_valid;
    logic                 i_span_ready = 1'b0;
    logic [RAD_W-1:0]     o_span_start;
    logic [DIM_W-1:0]     o_span_length;
    logic                 o_span_present;

    logic [ROW_W-1:0] rows_to_send[$];
    span_t            pending_spans[$];
    span_t            want;
    int unsigned      mismatches = 0;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 0;
    int unsigned      gap_left = 0;
    int unsigned      stall_mode = 0;

    // Local copy of the frame registers, updated on every accepted write.
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;
    logic [DIM_W-1:0] radius_req;

    rounded_rect_row_span_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_row_valid    (i_row_valid),
        .o_row_ready    (o_row_ready),
        .i_row_index    (i_row_index),
        .o_span_valid   (o_span_valid),
        .i_span_ready   (i_span_ready),
        .o_span_start   (o_span_start),
        .o_span_length  (o_span_length),
        .o_span_present (o_span_present)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v);
        return (v > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : int'(v);
    endfunction

    function automatic span_t span_of_row(input logic [ROW_W-1:0] row);
        int unsigned w, h, r, y, half, d, n, root, trial, inset;
        span_t s;
        w = clip_dim(frame_w);
        h = clip_dim(frame_h);
        r = clip_dim(radius_req);
        y = 32'(row);
        half = ((w < h) ? w : h) >> 1;
        if (r > half)
            r = half;
        inset = 0;
        d = 0;
        s = '0;
        if (y >= h)
            return s;
        // d is twice the vertical distance from the corner centre to the pixel centre.
        if (r != 0 && y < r)
            d = 2 * r - 2 * y - 1;
        else if (r != 0 && y >= h - r)
            d = 2 * y + 2 * r + 1 - 2 * h;
        if (d != 0) begin
            n = 4 * r * r - d * d;
            root = 0;
            for (int b = 13; b >= 0; b--) begin
                trial = root | (32'd1 << b);
                if (trial * trial <= n)
                    root = trial;
            end
            inset = r - (root >> 1);
        end
        if (w > 2 * inset) begin
            s.start = inset[RAD_W-1:0];
            s.length = DIM_W'(w - 2 * inset);
            s.present = 1'b1;
        end
        return s;
    endfunction

    // Row sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_row_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_row_valid || o_row_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_row_valid <= 1'b0;
            end else if (rows_to_send.size() != 0) begin
                i_row_valid <= 1'b1;
                i_row_index <= rows_to_send.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_row_valid <= 1'b0;
            end
        end
    end

    // Result receiver: a new stall pattern is picked whenever the low six bits of the cycle counter are zero.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("DONE: errors detected");
            $finish;
        end
        if (!i_rst_n) begin
            i_span_ready <= 1'b0;
        end else begin
            if (cycle_count[5:0] == 6'd0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: i_span_ready <= 1'b1;
                1: i_span_ready <= ($urandom_range(0, 3) != 0);
                2: i_span_ready <= cycle_count[0];
                default: i_span_ready <= (cycle_count[2:0] == 3'd0);
            endcase
        end
    end

    // Register copy, prediction on row acceptance, and checking of results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_w = '0;
            frame_h = '0;
            radius_req = RADIUS_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: frame_w = i_cfg_data;
                    REG_FRAME_HEIGHT: frame_h = i_cfg_data;
                    REG_CORNER_RADIUS: radius_req = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_row_valid && o_row_ready)
                pending_spans.push_back(span_of_row(i_row_index));
            if (o_span_valid && i_span_ready) begin
                if (pending_spans.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected span start %0d length %0d present %0d",
                             $time, o_span_start, o_span_length, o_span_present);
                end else begin
                    want = pending_spans.pop_front();
                    if (o_span_start !== want.start) begin
                        mismatches++;
                        $display("%0t: span_start expected %0d, got %0d",
                                 $time, want.start, o_span_start);
                    end
                    if (o_span_length !== want.length) begin
                        mismatches++;
                        $display("%0t: span_length expected %0d, got %0d",
                                 $time, want.length, o_span_length);
                    end
                    if (o_span_present !== want.present) begin
                        mismatches++;
                        $display("%0t: span_present expected %0d, got %0d",
                                 $time, want.present, o_span_present);
                    end
                end
            end
        end
    end

    // Must be entered at a rising edge; leaves the request raised for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [DIM_W-1:0] r);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CORNER_RADIUS, r);
        i_cfg_valid <= 1'b0;
    endtask

    // Returns at a rising edge once every row has gone and every span has come back.
    task automatic drain();
        do @(negedge i_clk);
        while (rows_to_send.size() != 0 || i_row_valid || pending_spans.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int unsigned n_rows);
        int unsigned w, h, r, hh, rr, pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            w = $urandom_range(0, 8191);
            h = $urandom_range(0, 8191);
            r = $urandom_range(0, 8191);
        end else if (pick == 1) begin
            w = $urandom_range(3000, 4096);
            h = $urandom_range(3000, 4096);
            r = $urandom_range(0, 2100);
        end else begin
            w = $urandom_range(0, 300);
            h = $urandom_range(0, 300);
            r = $urandom_range(0, 160);
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE, DIM_W'($urandom_range(0, 8191)));
        set_frame(DIM_W'(w), DIM_W'(h), DIM_W'(r));
        hh = (h > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : h;
        rr = (r > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : r;
        w = (w > DEFAULT_MAX_DIM) ? DEFAULT_MAX_DIM : w;
        if (rr > ((w < hh) ? w : hh) / 2)
            rr = ((w < hh) ? w : hh) / 2;
        // Most rows fall in the rounded corners, where the square root is exercised.
        repeat (n_rows) begin
            pick = $urandom_range(0, 9);
            if (pick < 6 && rr != 0) begin
                if ($urandom_range(0, 1) == 0)
                    rows_to_send.push_back(ROW_W'($urandom_range(0, rr - 1)));
                else
                    rows_to_send.push_back(ROW_W'(hh - 1 - $urandom_range(0, rr - 1)));
            end else if (pick < 9 && hh != 0) begin
                rows_to_send.push_back(ROW_W'($urandom_range(0, hh - 1)));
            end else begin
                rows_to_send.push_back(ROW_W'($urandom_range(0, 4095)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: an empty frame, so no row holds a span.
        rows_to_send = '{12'd0, 12'd4095};
        drain();

        // A write to the undecoded index must leave the frame alone.
        write_reg(REG_SPARE, 13'd77);
        set_frame(13'd100, 13'd60, 13'd18);
        rows_to_send = '{12'd0, 12'd17, 12'd18, 12'd41, 12'd42, 12'd59, 12'd60, 12'd4095};
        drain();

        // Oversized registers saturate, and the radius clamps to half the frame.
        set_frame(13'd8191, 13'd4096, 13'd8191);
        rows_to_send = '{12'd0, 12'd2047, 12'd2048, 12'd4095};
        drain();

        // A one pixel wide frame forces the radius to zero; zero width gives nothing.
        set_frame(13'd1, 13'd5, 13'd3);
        rows_to_send = '{12'd0, 12'd4};
        drain();
        set_frame(13'd0, 13'd5, 13'd3);
        rows_to_send = '{12'd2};
        drain();

        // The corner inset eats the whole row.
        set_frame(13'd2, 13'd2, 13'd1);
        rows_to_send = '{12'd0, 12'd1};
        drain();

        set_frame(13'd50, 13'd40, 13'd0);
        rows_to_send = '{12'd0, 12'd39};
        drain();

        repeat (12) random_phase(75);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_spans.size() != 0) begin
            mismatches++;
            $display("%0t: %0d spans never arrived", $time, pending_spans.size());
        end
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
